// File: src/mfe_pkg.sv
// Shared constants, types and arithmetic helpers for the material fatigue evaluator.
package mfe_pkg;

    localparam int FRAC_BITS = 32;
    localparam int FB_GAP    = 32 - FRAC_BITS;

    localparam logic [62:0] MAXV        = {63{1'b1}};
    localparam logic [63:0] ONE         = 64'd1 << FRAC_BITS;
    localparam logic [63:0] TENTH       = 64'd429496730 >> FB_GAP;
    localparam logic [63:0] THOUSANDTH  = 64'd4294967 >> FB_GAP;
    localparam logic [63:0] NINE_TENTHS = 64'd3865470566 >> FB_GAP;

    localparam logic [62:0] NOMINAL_YIELD_RST = 63'(64'd250000000 << FRAC_BITS);
    localparam logic [62:0] MELT_RST          = 63'(64'd1811 << FRAC_BITS);
    localparam logic [62:0] TOUGH_RST         = 63'(64'd100 << FRAC_BITS);
    localparam logic [62:0] STEP_RST          = 63'(64'd35791394 >> FB_GAP);

    typedef enum logic [1:0] {
        REG_NOMINAL_YIELD = 2'd0,
        REG_MELTING_POINT = 2'd1,
        REG_TOUGHNESS     = 2'd2,
        REG_TIME_STEP     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [63:0] ll;
        logic [63:0] lh;
        logic [63:0] hl;
        logic [63:0] hh;
    } mul_parts_t;

    // Four 32x32 partial products of a 64x64 multiply.
    function automatic mul_parts_t mul_parts(input logic [63:0] a, input logic [63:0] b);
        mul_parts_t p;
        p.ll = 64'(a[31:0]) * 64'(b[31:0]);
        p.lh = 64'(a[31:0]) * 64'(b[63:32]);
        p.hl = 64'(a[63:32]) * 64'(b[31:0]);
        p.hh = 64'(a[63:32]) * 64'(b[63:32]);
        return p;
    endfunction

    // Sum the partials, drop the fraction and saturate at MAXV.
    function automatic logic [62:0] mul_join(input mul_parts_t p);
        logic [127:0] s;
        s = {64'd0, p.ll} + {32'd0, p.lh, 32'd0} + {32'd0, p.hl, 32'd0} + {p.hh, 64'd0};
        if (|s[127:63+FRAC_BITS])
            return MAXV;
        return s[62+FRAC_BITS:FRAC_BITS];
    endfunction

    function automatic logic [63:0] abs_diff(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] df;
        df = {a[63], a} - {b[63], b};
        return df[64] ? 64'(-df) : df[63:0];
    endfunction

endpackage

// File: src/mfe_div.sv
// Pipelined restoring fixed-point divider, one quotient bit per stage.
module mfe_div
    import mfe_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  logic [63:0]       in_a,
    input  logic [63:0]       in_d,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_vld,
    output logic [62:0]       out_q,
    output logic [SIDE_W-1:0] out_side
);

    localparam int STEPS = 64;

    typedef struct packed {
        logic [63:0]       rem;
        logic [63:0]       lo;
        logic [63:0]       d;
        logic [63:0]       q;
        logic              ovf;
        logic [SIDE_W-1:0] side;
    } div_stage_t;

    div_stage_t       stg_reg  [0:STEPS];
    div_stage_t       stg_next [0:STEPS-1];
    logic [STEPS:0]   vld_reg;

    always_comb
    begin
        logic [63:0] trial;
        for (int i = 0; i < STEPS; i++)
        begin
            stg_next[i]    = stg_reg[i];
            trial          = {stg_reg[i].rem[62:0], stg_reg[i].lo[63]};
            stg_next[i].lo = stg_reg[i].lo << 1;
            if (trial >= stg_reg[i].d)
            begin
                stg_next[i].rem = trial - stg_reg[i].d;
                stg_next[i].q   = {stg_reg[i].q[62:0], 1'b1};
            end
            else
            begin
                stg_next[i].rem = trial;
                stg_next[i].q   = {stg_reg[i].q[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        stg_reg[0].rem  <= in_a >> (64 - FRAC_BITS);
        stg_reg[0].lo   <= in_a << FRAC_BITS;
        stg_reg[0].d    <= in_d;
        stg_reg[0].q    <= '0;
        stg_reg[0].ovf  <= (in_a >> (64 - FRAC_BITS)) >= in_d;
        stg_reg[0].side <= in_side;
        for (int i = 0; i < STEPS; i++)
            stg_reg[i+1] <= stg_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[STEPS-1:0], in_vld};
    end

    assign out_vld  = vld_reg[STEPS];
    assign out_q    = (stg_reg[STEPS].ovf || stg_reg[STEPS].q[63]) ? MAXV
                                                                  : stg_reg[STEPS].q[62:0];
    assign out_side = stg_reg[STEPS].side;

endmodule

// File: src/material_fatigue_evaluator.sv
// Top level of the material fatigue evaluator: von Mises stress, softened yield, fatigue.
//
// Usage
//   Configuration: APB-style port, 64-bit data, registers at byte addresses 0 (nominal yield),
//   8 (melting_point), 16 (toughness), 24 (time_step). pready is always high; a write lands
//   on the access cycle. Write only while no element is in flight.
//   Input: one element per transfer, taken at any rising edge with start high. busy is
//   never raised, so an element may enter on every cycle.
//   Output: done pulses for one cycle with fatigue_out, dynamic_yield and integrity; the
//   receiver cannot hold results off, and none is needed since nothing stalls.
//   Pipeline: the bulk of its depth comes from three 64-stage dividers (temperature ratio,
//   stress ratio, life fraction) and the 48-stage square root, all in series.
//   Throughput: one element per cycle; every stage is a register stage of its own.
//   Reset: clears every valid bit and loads the register defaults; in-flight work is lost.
module material_fatigue_evaluator
    import mfe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic signed [63:0] stress_one,
    input  logic signed [63:0] stress_two,
    input  logic signed [63:0] stress_three,
    input  logic signed [63:0] temperature,
    input  logic [62:0]        fatigue_in,
    output logic               done,
    output logic [62:0]        fatigue_out,
    output logic [62:0]        dynamic_yield,
    output logic [32:0]        integrity
);

    localparam int SQRT_STEPS = 48;

    // ---------------- configuration registers ----------------
    logic [62:0] nominal_yield_reg;
    logic [62:0] melting_point_reg;
    logic [62:0] toughness_reg;
    logic [62:0] time_step_reg;
    mul_parts_t  rec_parts_reg;
    logic [62:0] rec_reg;

    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nominal_yield_reg <= NOMINAL_YIELD_RST;
            melting_point_reg <= MELT_RST;
            toughness_reg     <= TOUGH_RST;
            time_step_reg     <= STEP_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx_t'(paddr[4:3]))
                REG_NOMINAL_YIELD: nominal_yield_reg <= pwdata[62:0];
                REG_MELTING_POINT: melting_point_reg <= pwdata[62:0];
                REG_TOUGHNESS:     toughness_reg     <= pwdata[62:0];
                REG_TIME_STEP:     time_step_reg     <= pwdata[62:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[4:3]))
            REG_NOMINAL_YIELD: prdata = {1'b0, nominal_yield_reg};
            REG_MELTING_POINT: prdata = {1'b0, melting_point_reg};
            REG_TOUGHNESS:     prdata = {1'b0, toughness_reg};
            REG_TIME_STEP:     prdata = {1'b0, time_step_reg};
        endcase
    end

    // Recovery per step follows time_step through rec_parts_reg and then rec_reg,
    // settling long before any element reaches the fatigue update.
    always_ff @(posedge clk)
    begin
        rec_parts_reg <= mul_parts(THOUSANDTH, {1'b0, time_step_reg});
        rec_reg       <= mul_join(rec_parts_reg);
    end

    // ---------------- stress front end: differences, squares, sum ----------------
    typedef struct packed {
        logic [63:0] d12;
        logic [63:0] d23;
        logic [63:0] d31;
        logic [63:0] temp;
        logic [62:0] fat;
    } diff_t;

    typedef struct packed {
        mul_parts_t  p12;
        mul_parts_t  p23;
        mul_parts_t  p31;
        logic [63:0] temp;
        logic [62:0] fat;
    } sqp_t;

    typedef struct packed {
        logic [62:0] sq12;
        logic [62:0] sq23;
        logic [62:0] sq31;
        logic [63:0] temp;
        logic [62:0] fat;
    } sqr_t;

    typedef struct packed {
        logic [95:0] n;
        logic [47:0] root;
        logic [51:0] rem;
        logic [63:0] temp;
        logic [62:0] fat;
    } sqrt_t;

    diff_t a_reg;
    sqp_t  b_reg;
    sqr_t  c_reg;
    logic  a_vld_reg, b_vld_reg, c_vld_reg;

    sqrt_t              sq_reg  [0:SQRT_STEPS];
    sqrt_t              sq_next [0:SQRT_STEPS-1];
    logic [SQRT_STEPS:0] sq_vld_reg;
    logic [64:0]        sum_wide;
    logic [62:0]        sum_sat;

    // Capture the element and form the exact stress differences.
    always_ff @(posedge clk)
    begin
        a_reg.d12  <= abs_diff(stress_one, stress_two);
        a_reg.d23  <= abs_diff(stress_two, stress_three);
        a_reg.d31  <= abs_diff(stress_three, stress_one);
        a_reg.temp <= temperature;
        a_reg.fat  <= fatigue_in;

        b_reg.p12  <= mul_parts(a_reg.d12, a_reg.d12);
        b_reg.p23  <= mul_parts(a_reg.d23, a_reg.d23);
        b_reg.p31  <= mul_parts(a_reg.d31, a_reg.d31);
        b_reg.temp <= a_reg.temp;
        b_reg.fat  <= a_reg.fat;

        c_reg.sq12 <= mul_join(b_reg.p12);
        c_reg.sq23 <= mul_join(b_reg.p23);
        c_reg.sq31 <= mul_join(b_reg.p31);
        c_reg.temp <= b_reg.temp;
        c_reg.fat  <= b_reg.fat;
    end

    // Saturating sum of the three squares, halved, seeds the root.
    assign sum_wide = 65'(c_reg.sq12) + 65'(c_reg.sq23) + 65'(c_reg.sq31);
    assign sum_sat  = (sum_wide > 65'(MAXV)) ? MAXV : sum_wide[62:0];

    // Digit-by-digit square root: two radicand bits in, one root bit out per stage.
    always_comb
    begin
        logic [51:0] t;
        logic [51:0] trial;
        for (int i = 0; i < SQRT_STEPS; i++)
        begin
            sq_next[i]   = sq_reg[i];
            t            = {sq_reg[i].rem[49:0], sq_reg[i].n[95:94]};
            trial        = {2'b00, sq_reg[i].root, 2'b01};
            sq_next[i].n = sq_reg[i].n << 2;
            if (t >= trial)
            begin
                sq_next[i].rem  = t - trial;
                sq_next[i].root = {sq_reg[i].root[46:0], 1'b1};
            end
            else
            begin
                sq_next[i].rem  = t;
                sq_next[i].root = {sq_reg[i].root[46:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg[0].n    <= 96'(sum_sat >> 1) << FRAC_BITS;
        sq_reg[0].root <= '0;
        sq_reg[0].rem  <= '0;
        sq_reg[0].temp <= c_reg.temp;
        sq_reg[0].fat  <= c_reg.fat;
        for (int i = 0; i < SQRT_STEPS; i++)
            sq_reg[i+1] <= sq_next[i];
    end

    // ---------------- thermal softening ----------------
    typedef struct packed {
        logic [47:0] eq;
        logic [62:0] fat;
        logic        tneg;
    } d1_side_t;

    typedef struct packed {
        logic [47:0] eq;
        logic [62:0] fat;
        logic        rone;
        logic [63:0] val;
        mul_parts_t  parts;
        logic [62:0] yield;
    } soft_t;

    d1_side_t   d1_side_in, d1_side_out;
    logic       d1_vld;
    logic [62:0] d1_q;

    soft_t e_reg, f_reg, g_reg, h_reg, i_reg, j_reg, k_reg;
    soft_t e_next, f_next, g_next, h_next, i_next, j_next, k_next;
    logic [6:0] y_vld_reg;

    assign d1_side_in.eq   = sq_reg[SQRT_STEPS].root;
    assign d1_side_in.fat  = sq_reg[SQRT_STEPS].fat;
    assign d1_side_in.tneg = sq_reg[SQRT_STEPS].temp[63];

    // Temperature over melting point plus one LSB.
    mfe_div #(
        .SIDE_W ($bits(d1_side_t))
    ) u_div_temp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (sq_vld_reg[SQRT_STEPS]),
        .in_a     (sq_reg[SQRT_STEPS].temp),
        .in_d     ({1'b0, melting_point_reg} + 64'd1),
        .in_side  (d1_side_in),
        .out_vld  (d1_vld),
        .out_q    (d1_q),
        .out_side (d1_side_out)
    );

    always_comb
    begin
        // Clamp the ratio to [0, 1]; a negative temperature gives no softening.
        e_next       = '0;
        e_next.eq    = d1_side_out.eq;
        e_next.fat   = d1_side_out.fat;
        e_next.rone  = !d1_side_out.tneg && (64'(d1_q) >= ONE);
        if (d1_side_out.tneg)
            e_next.val = '0;
        else if (64'(d1_q) > ONE)
            e_next.val = ONE;
        else
            e_next.val = 64'(d1_q);

        f_next       = e_reg;
        f_next.parts = mul_parts(e_reg.val, e_reg.val);

        g_next       = f_reg;
        g_next.val   = 64'(mul_join(f_reg.parts));

        h_next       = g_reg;
        h_next.parts = mul_parts({1'b0, nominal_yield_reg}, ONE - g_reg.val);

        i_next       = h_reg;
        i_next.yield = mul_join(h_reg.parts);

        j_next       = i_reg;
        j_next.parts = mul_parts({1'b0, i_reg.yield}, TENTH);

        // val now holds the endurance limit
        k_next       = j_reg;
        k_next.val   = 64'(mul_join(j_reg.parts));
    end

    always_ff @(posedge clk)
    begin
        e_reg <= e_next;
        f_reg <= f_next;
        g_reg <= g_next;
        h_reg <= h_next;
        i_reg <= i_next;
        j_reg <= j_next;
        k_reg <= k_next;
    end

    // ---------------- damage or recovery ----------------
    typedef struct packed {
        logic [62:0] yield;
        logic [62:0] fat;
        logic        hit;
        logic        rone;
    } d2_side_t;

    typedef struct packed {
        logic [63:0] val;
        mul_parts_t  parts;
        logic [62:0] yield;
        logic [62:0] fat;
        logic        hit;
        logic        rone;
    } dmg_t;

    d2_side_t   d2_side_in, d2_side_out;
    logic       d2_vld;
    logic [62:0] d2_q;

    dmg_t l_reg, m_reg, n_reg, o_reg, p_reg, q_reg, r_reg;
    dmg_t l_next, m_next, n_next, o_next, p_next, q_next, r_next;
    logic [6:0] f_vld_reg;
    logic [63:0] fat_sum;

    assign d2_side_in.yield = k_reg.yield;
    assign d2_side_in.fat   = k_reg.fat;
    assign d2_side_in.hit   = 64'(k_reg.eq) > k_reg.val;
    assign d2_side_in.rone  = k_reg.rone;

    // Stress over softened yield plus one LSB.
    mfe_div #(
        .SIDE_W ($bits(d2_side_t))
    ) u_div_stress (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (y_vld_reg[6]),
        .in_a     (64'(k_reg.eq)),
        .in_d     ({1'b0, k_reg.yield} + 64'd1),
        .in_side  (d2_side_in),
        .out_vld  (d2_vld),
        .out_q    (d2_q),
        .out_side (d2_side_out)
    );

    assign fat_sum = 64'(q_reg.fat) + q_reg.val;

    always_comb
    begin
        l_next       = '0;
        l_next.yield = d2_side_out.yield;
        l_next.fat   = d2_side_out.fat;
        l_next.hit   = d2_side_out.hit;
        l_next.rone  = d2_side_out.rone;
        l_next.parts = mul_parts({1'b0, d2_q}, {1'b0, d2_q});

        m_next       = l_reg;
        m_next.val   = 64'(mul_join(l_reg.parts));

        n_next       = m_reg;
        n_next.parts = mul_parts(m_reg.val, m_reg.val);

        o_next       = n_reg;
        o_next.val   = 64'(mul_join(n_reg.parts));

        p_next       = o_reg;
        p_next.parts = mul_parts(o_reg.val, {1'b0, time_step_reg});

        q_next       = p_reg;
        q_next.val   = 64'(mul_join(p_reg.parts));

        // Add damage with saturation, or relax toward zero.
        r_next = q_reg;
        if (q_reg.hit)
            r_next.fat = (fat_sum > 64'(MAXV)) ? MAXV : fat_sum[62:0];
        else if (q_reg.fat > rec_reg)
            r_next.fat = q_reg.fat - rec_reg;
        else
            r_next.fat = '0;
    end

    always_ff @(posedge clk)
    begin
        l_reg <= l_next;
        m_reg <= m_next;
        n_reg <= n_next;
        o_reg <= o_next;
        p_reg <= p_next;
        q_reg <= q_next;
        r_reg <= r_next;
    end

    // ---------------- life fraction and integrity ----------------
    typedef struct packed {
        logic [62:0] yield;
        logic [62:0] fat;
        logic        rone;
    } d3_side_t;

    typedef struct packed {
        logic [63:0] a_op;
        logic [63:0] b_op;
        mul_parts_t  parts;
        logic        zero;
        logic        use_mul;
        logic [62:0] yield;
        logic [62:0] fat;
    } integ_t;

    d3_side_t    d3_side_in, d3_side_out;
    logic        d3_vld;
    logic [62:0] d3_q;
    logic [63:0] life_ext;
    logic [63:0] over;
    logic [63:0] snap;

    integ_t s_reg, t_reg;
    integ_t s_next, t_next;
    logic   s_vld_reg, t_vld_reg, done_reg;
    logic [62:0] fat_out_reg;
    logic [62:0] yield_out_reg;
    logic [32:0] integ_out_reg;
    logic [62:0] snap_prod;

    assign d3_side_in.yield = r_reg.yield;
    assign d3_side_in.fat   = r_reg.fat;
    assign d3_side_in.rone  = r_reg.rone;

    // Fatigue over toughness plus one LSB.
    mfe_div #(
        .SIDE_W ($bits(d3_side_t))
    ) u_div_life (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (f_vld_reg[6]),
        .in_a     ({1'b0, r_reg.fat}),
        .in_d     ({1'b0, toughness_reg} + 64'd1),
        .in_side  (d3_side_in),
        .out_vld  (d3_vld),
        .out_q    (d3_q),
        .out_side (d3_side_out)
    );

    assign life_ext  = 64'(d3_q);
    assign over      = life_ext - NINE_TENTHS;
    assign snap      = (over << 3) + (over << 1);
    assign snap_prod = mul_join(t_reg.parts);

    always_comb
    begin
        // Zero at melting, at end of life, or once the snap factor reaches one.
        s_next         = '0;
        s_next.yield   = d3_side_out.yield;
        s_next.fat     = d3_side_out.fat;
        s_next.a_op    = ONE - life_ext;
        s_next.b_op    = ONE - snap;
        s_next.use_mul = life_ext > NINE_TENTHS;
        s_next.zero    = d3_side_out.rone || (life_ext >= ONE)
                       || ((life_ext > NINE_TENTHS) && (snap >= ONE));

        t_next         = s_reg;
        t_next.parts   = mul_parts(s_reg.a_op, s_reg.b_op);
    end

    always_ff @(posedge clk)
    begin
        s_reg         <= s_next;
        t_reg         <= t_next;
        fat_out_reg   <= t_reg.fat;
        yield_out_reg <= t_reg.yield;
        if (t_reg.zero)
            integ_out_reg <= '0;
        else if (t_reg.use_mul)
            integ_out_reg <= snap_prod[32:0];
        else
            integ_out_reg <= t_reg.a_op[32:0];
    end

    // ---------------- valid bits ----------------
    // Advance every valid bit each cycle; nothing downstream can stall.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
            c_vld_reg  <= 1'b0;
            sq_vld_reg <= '0;
            y_vld_reg  <= '0;
            f_vld_reg  <= '0;
            s_vld_reg  <= 1'b0;
            t_vld_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            a_vld_reg  <= start && !busy;
            b_vld_reg  <= a_vld_reg;
            c_vld_reg  <= b_vld_reg;
            sq_vld_reg <= {sq_vld_reg[SQRT_STEPS-1:0], c_vld_reg};
            y_vld_reg  <= {y_vld_reg[5:0], d1_vld};
            f_vld_reg  <= {f_vld_reg[5:0], d2_vld};
            s_vld_reg  <= d3_vld;
            t_vld_reg  <= s_vld_reg;
            done_reg   <= t_vld_reg;
        end
    end

    assign done          = done_reg;
    assign fatigue_out   = fat_out_reg;
    assign dynamic_yield = yield_out_reg;
    assign integrity     = integ_out_reg;

    // ---------------- assertions ----------------
    a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (integrity <= 33'(ONE)))
        else $error("integrity above one");

    a_yield_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (dynamic_yield <= nominal_yield_reg))
        else $error("softened yield above nominal yield");

    a_life_left: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (integrity != 33'd0)) |-> (fatigue_out <= toughness_reg))
        else $error("integrity left after fatigue passed toughness");

endmodule
